FILE: sv/bfef_pkg.sv
// Shared constants and types of the binary fraction estimate fusion block
`timescale 1ns / 1ps

package bfef_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CONF_BITS  = 48;
  localparam int FRAC_BITS  = 16;
  localparam int EST_BITS   = FRAC_BITS + 1;
  localparam int FLOOR_BITS = 16;
  localparam int ACC_BITS   = 64;
  localparam int SQ_BITS    = 2 * COUNT_BITS + 1;
  localparam int DW         = 100;
  localparam int MB         = 34;
  localparam int ITER_BITS  = 7;

  localparam logic [EST_BITS-1:0]  EST_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CONF_BITS-1:0] CONF_MAX = '1;
  localparam logic [ACC_BITS-1:0]  ACC_MAX  = '1;

  localparam logic [1:0] CMD_LOCAL    = 2'd0;
  localparam logic [1:0] CMD_NEIGHBOR = 2'd1;
  localparam logic [1:0] CMD_CLOSE    = 2'd2;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

endpackage

FILE: sv/bfef_if.sv
// Handshake channels of the binary fraction estimate fusion block
`timescale 1ns / 1ps

interface bfef_in_if import bfef_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [COUNT_BITS-1:0] black_count;
  logic [COUNT_BITS-1:0] observation_count;
  logic [EST_BITS-1:0]   acc_black;
  logic [EST_BITS-1:0]   acc_white;
  logic [EST_BITS-1:0]   neighbor_estimate;
  logic [CONF_BITS-1:0]  neighbor_confidence;

  modport source (output valid, command, black_count, observation_count, acc_black,
                  acc_white, neighbor_estimate, neighbor_confidence, input ready);
  modport sink (input valid, command, black_count, observation_count, acc_black,
                acc_white, neighbor_estimate, neighbor_confidence, output ready);
endinterface

interface bfef_out_if import bfef_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [EST_BITS-1:0]  estimate;
  logic [CONF_BITS-1:0] confidence;
  logic [EST_BITS-1:0]  social_estimate;
  logic [CONF_BITS-1:0] social_confidence;
  logic                 saturated;

  modport source (output valid, kind, estimate, confidence, social_estimate,
                  social_confidence, saturated, input ready);
  modport sink (input valid, kind, estimate, confidence, social_estimate,
                social_confidence, saturated, output ready);
endinterface

interface bfef_cfg_if import bfef_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FLOOR_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/bfef_unit.sv
// Shared shift-add multiplier and restoring divider
`timescale 1ns / 1ps

module bfef_unit import bfef_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  unit_req_t     req,
  input  logic [DW-1:0] op_a,
  input  logic [DW-1:0] op_b,
  output logic          done,
  output logic [DW-1:0] res
);

  logic                 busy_r;
  logic                 done_r;
  unit_op_t             op_r;
  logic [ITER_BITS-1:0] cnt_r;
  logic [DW-1:0]        acc_r;
  logic [DW-1:0]        sa_r;
  logic [DW-1:0]        sb_r;
  logic [DW-1:0]        rem_r;
  logic [DW:0]          rem_sh;
  logic [DW:0]          rem_dif;
  logic                 ge;

  assign rem_sh  = {rem_r, sa_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, sb_r};
  assign rem_dif = rem_sh - {1'b0, sb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        acc_r  <= '0;
        rem_r  <= '0;
        sa_r   <= op_a;
        sb_r   <= op_b;
        cnt_r  <= (req.op == OP_MUL) ? ITER_BITS'(MB) : ITER_BITS'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ITER_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        case (op_r)
          OP_MUL: begin
            if (sb_r[0]) acc_r <= acc_r + sa_r;
            sa_r <= {sa_r[DW-2:0], 1'b0};
            sb_r <= {1'b0, sb_r[DW-1:1]};
          end
          default: begin
            rem_r <= ge ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
            acc_r <= {acc_r[DW-2:0], ge};
            sa_r  <= {sa_r[DW-2:0], 1'b0};
          end
        endcase
      end
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

FILE: sv/binary_fraction_estimate_fusion.sv
// Top level: command sequencer, state and result register of the estimate fusion block
//
//  channel  | dir | handshake     | beat
//  in_bus   | in  | valid / ready | command, counts, accuracies, neighbour estimate
//  out_bus  | out | valid / ready | kind, estimates, confidences, saturated flag
//  cfg_bus  | in  | valid / ready | confidence floor, always ready
//
// One beat at a time; every multiply and every divide runs in the shared unit.
// Synchronous active-low reset; no clearing pass. A stalled result holds the
// sequencer in its output state.
`timescale 1ns / 1ps

module binary_fraction_estimate_fusion import bfef_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bfef_in_if.sink     in_bus,
  bfef_out_if.source  out_bus,
  bfef_cfg_if.sink    cfg_bus
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH,
    S_P_TT, S_P_TTT, S_P_HG, S_P_EST, S_P_CONF,
    S_R_TW, S_R_DT, S_R_DD, S_R_BRANCH,
    S_C_XX, S_C_YY, S_C_DEN, S_C_ON, S_C_OFF, S_C_NUM, S_C_DIV,
    S_E_EST, S_E_TT, S_E_TTT, S_E_TD2, S_E_HG, S_E_DIV,
    S_N_HI, S_N_LO, S_N_ACC,
    S_K_SX, S_K_LE, S_K_SX2, S_K_EST,
    S_FLOOR, S_OUT
  } state_t;

  state_t                state_r;
  logic                  wait_r;
  logic [1:0]            cmd_r;
  logic [COUNT_BITS-1:0] t_r, h_r;
  logic [EST_BITS-1:0]   a_r, w_r, ne_r;
  logic [CONF_BITS-1:0]  nc_r;
  logic [DW-1:0]         x_r, y_r, z_r, u_r;
  logic [SQ_BITS-1:0]    d2_r;
  logic [EST_BITS-1:0]   est_r, le_r, sx_r;
  logic [CONF_BITS-1:0]  conf_r, lc_r, sc_r, cs_r;
  logic [ACC_BITS-1:0]   ws_r;
  logic                  flag_r, hi_r, seen_r;
  logic [FLOOR_BITS-1:0] floor_r;

  logic                  out_valid_r, out_kind_r, out_sat_r;
  logic [EST_BITS-1:0]   out_est_r, out_sx_r;
  logic [CONF_BITS-1:0]  out_conf_r, out_sc_r;

  logic [COUNT_BITS-1:0] g_w, h_in;
  logic [EST_BITS-1:0]   a_in, w_in, ne_in;
  logic signed [35:0]    num_s, num_n;
  logic [35:0]           num_mag;
  logic signed [17:0]    dd_s, dd_n;
  logic [EST_BITS-1:0]   dd_mag, xsel, omx;
  logic [COUNT_BITS-1:0] onsel, offsel;
  logic [CONF_BITS:0]    dsum, cs_sum;
  logic [49:0]           prod;
  logic [ACC_BITS:0]     ws_sum;
  logic [CONF_BITS-1:0]  conf_fl;

  unit_req_t             req;
  logic [DW-1:0]         op_a, op_b, div_max, u_res, cap_val;
  logic                  is_op, u_done, dz, cap, cap_flag, over;

  assign h_in  = (in_bus.black_count > in_bus.observation_count) ?
                 in_bus.observation_count : in_bus.black_count;
  assign a_in  = (in_bus.acc_black > EST_ONE) ? EST_ONE : in_bus.acc_black;
  assign w_in  = (in_bus.acc_white > EST_ONE) ? EST_ONE : in_bus.acc_white;
  assign ne_in = (in_bus.neighbor_estimate > EST_ONE) ? EST_ONE : in_bus.neighbor_estimate;

  assign g_w     = t_r - h_r;
  assign num_s   = $signed({4'b0, h_r, {FRAC_BITS{1'b0}}}) + $signed({3'b0, x_r[SQ_BITS-1:0]})
                 - $signed({4'b0, t_r, {FRAC_BITS{1'b0}}});
  assign num_n   = -num_s;
  assign num_mag = num_s[35] ? num_n : num_s;
  assign dd_s    = $signed({1'b0, a_r}) + $signed({1'b0, w_r}) - $signed({1'b0, EST_ONE});
  assign dd_n    = -dd_s;
  assign dd_mag  = dd_s[17] ? dd_n[EST_BITS-1:0] : dd_s[EST_BITS-1:0];
  assign xsel    = hi_r ? a_r : w_r;
  assign omx     = EST_ONE - xsel;
  assign onsel   = hi_r ? g_w : h_r;
  assign offsel  = hi_r ? h_r : g_w;
  assign dsum    = {1'b0, lc_r} + {1'b0, sc_r};
  assign prod    = x_r[49:0] + 50'(y_r[DW-1:FRAC_BITS]);
  assign ws_sum  = {1'b0, ws_r} + (ACC_BITS+1)'(prod);
  assign cs_sum  = {1'b0, cs_r} + {1'b0, nc_r};
  assign conf_fl = (conf_r <= CONF_BITS'(floor_r)) ? CONF_BITS'(floor_r) : conf_r;

  always_comb begin
    is_op   = 1'b1;
    req.op  = OP_MUL;
    op_a    = '0;
    op_b    = '0;
    div_max = DW'(EST_ONE);
    unique case (state_r)
      S_P_TT:   begin op_a = DW'(t_r); op_b = DW'(t_r); end
      S_P_TTT:  begin op_a = x_r; op_b = DW'(t_r); end
      S_P_HG:   begin op_a = DW'(h_r); op_b = DW'(g_w); end
      S_P_EST:  begin
        req.op = OP_DIV; op_a = DW'({h_r, {FRAC_BITS{1'b0}}}); op_b = DW'(t_r);
      end
      S_P_CONF: begin
        req.op = OP_DIV; op_a = {x_r[DW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}; op_b = y_r;
        div_max = DW'(CONF_MAX);
      end
      S_R_TW:   begin op_a = DW'(t_r); op_b = DW'(w_r); end
      S_R_DT:   begin op_a = DW'(dd_mag); op_b = DW'(t_r); end
      S_R_DD:   begin op_a = DW'(dd_mag); op_b = DW'(dd_mag); end
      S_C_XX:   begin op_a = DW'(xsel); op_b = DW'(xsel); end
      S_C_YY:   begin op_a = DW'(omx); op_b = DW'(omx); end
      S_C_DEN:  begin op_a = y_r; op_b = z_r; end
      S_C_ON:   begin op_a = y_r; op_b = DW'(onsel); end
      S_C_OFF:  begin op_a = z_r; op_b = DW'(offsel); end
      S_C_NUM:  begin op_a = y_r + z_r; op_b = DW'(d2_r); end
      S_C_DIV:  begin
        req.op = OP_DIV; op_a = {y_r[DW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}; op_b = u_r;
        div_max = DW'(CONF_MAX);
      end
      S_E_EST:  begin
        req.op = OP_DIV; op_a = DW'({num_mag, {FRAC_BITS{1'b0}}}); op_b = y_r;
      end
      S_E_TT:   begin op_a = DW'(t_r); op_b = DW'(t_r); end
      S_E_TTT:  begin op_a = x_r; op_b = DW'(t_r); end
      S_E_TD2:  begin op_a = x_r; op_b = DW'(d2_r); end
      S_E_HG:   begin op_a = DW'(h_r); op_b = DW'(g_w); end
      S_E_DIV:  begin
        req.op = OP_DIV; op_a = x_r; op_b = {z_r[DW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        div_max = DW'(CONF_MAX);
      end
      S_N_HI:   begin op_a = DW'(nc_r[CONF_BITS-1:FRAC_BITS]); op_b = DW'(ne_r); end
      S_N_LO:   begin op_a = DW'(nc_r[FRAC_BITS-1:0]); op_b = DW'(ne_r); end
      S_K_SX:   begin req.op = OP_DIV; op_a = DW'({ws_r, {FRAC_BITS{1'b0}}}); op_b = DW'(cs_r); end
      S_K_LE:   begin op_a = DW'(lc_r); op_b = DW'(le_r); end
      S_K_SX2:  begin op_a = DW'(sc_r); op_b = DW'(sx_r); end
      S_K_EST:  begin req.op = OP_DIV; op_a = x_r + y_r; op_b = DW'(dsum); end
      default:  is_op = 1'b0;
    endcase
    req.start = is_op && !wait_r && !((req.op == OP_DIV) && (op_b == '0));
  end

  assign dz        = (req.op == OP_DIV) && (op_b == '0);
  assign cap       = is_op && (wait_r ? u_done : dz);
  assign over      = u_res > div_max;
  assign cap_flag  = (req.op == OP_DIV) && (dz || over);
  assign cap_val   = (req.op == OP_MUL) ? u_res : ((dz || over) ? div_max : u_res);

  bfef_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .op_a (op_a),
    .op_b (op_b),
    .done (u_done),
    .res  (u_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      floor_r     <= FLOOR_BITS'(1);
      cs_r        <= CONF_BITS'(1);
      ws_r        <= '0;
      seen_r      <= 1'b0;
      lc_r        <= '0;
      le_r        <= '0;
    end else begin
      if (cfg_bus.valid) begin
        floor_r <= cfg_bus.data;
        if (!seen_r) cs_r <= CONF_BITS'(cfg_bus.data);
      end
      if (out_valid_r && out_bus.ready) out_valid_r <= 1'b0;
      if (req.start) wait_r <= 1'b1;
      if (cap) begin
        wait_r <= 1'b0;
        flag_r <= flag_r | cap_flag;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_bus.valid) begin
            cmd_r   <= in_bus.command;
            t_r     <= in_bus.observation_count;
            h_r     <= h_in;
            a_r     <= a_in;
            w_r     <= w_in;
            ne_r    <= ne_in;
            nc_r    <= in_bus.neighbor_confidence;
            flag_r  <= 1'b0;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (cmd_r)
            CMD_LOCAL: begin
              sx_r <= '0;
              sc_r <= '0;
              if (t_r == '0) begin
                est_r   <= '0;
                conf_r  <= CONF_MAX;
                flag_r  <= 1'b1;
                state_r <= S_FLOOR;
              end else if (a_r == EST_ONE && w_r == EST_ONE) begin
                state_r <= S_P_TT;
              end else begin
                state_r <= S_R_TW;
              end
            end
            CMD_NEIGHBOR: state_r <= S_N_HI;
            CMD_CLOSE: begin
              flag_r  <= (ws_r == ACC_MAX) || (cs_r == CONF_MAX);
              sc_r    <= seen_r ? cs_r : '0;
              state_r <= S_K_SX;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_P_TT:   if (cap) begin x_r <= cap_val; state_r <= S_P_TTT; end
        S_P_TTT:  if (cap) begin x_r <= cap_val; state_r <= S_P_HG; end
        S_P_HG:   if (cap) begin y_r <= cap_val; state_r <= S_P_EST; end
        S_P_EST:  if (cap) begin est_r <= cap_val[EST_BITS-1:0]; state_r <= S_P_CONF; end
        S_P_CONF: if (cap) begin conf_r <= cap_val[CONF_BITS-1:0]; state_r <= S_FLOOR; end
        S_R_TW:   if (cap) begin x_r <= cap_val; state_r <= S_R_DT; end
        S_R_DT:   if (cap) begin y_r <= cap_val; state_r <= S_R_DD; end
        S_R_DD:   if (cap) begin d2_r <= cap_val[SQ_BITS-1:0]; state_r <= S_R_BRANCH; end
        S_R_BRANCH: begin
          state_r <= S_C_XX;
          if (dd_s == '0) begin
            flag_r <= 1'b1;
            hi_r   <= (num_s > 0);
          end else if (num_s == '0 || (num_s[35] != dd_s[17])) begin
            hi_r <= 1'b0;
          end else if (num_mag >= {3'b0, y_r[SQ_BITS-1:0]}) begin
            hi_r <= 1'b1;
          end else begin
            state_r <= S_E_EST;
          end
          est_r <= (dd_s != '0 && num_s != '0 && num_s[35] == dd_s[17] &&
                    num_mag >= {3'b0, y_r[SQ_BITS-1:0]}) || (dd_s == '0 && num_s > 0) ?
                   EST_ONE : '0;
        end
        S_C_XX:   if (cap) begin y_r <= cap_val; state_r <= S_C_YY; end
        S_C_YY:   if (cap) begin z_r <= cap_val; state_r <= S_C_DEN; end
        S_C_DEN:  if (cap) begin u_r <= cap_val; state_r <= S_C_ON; end
        S_C_ON:   if (cap) begin y_r <= cap_val; state_r <= S_C_OFF; end
        S_C_OFF:  if (cap) begin z_r <= cap_val; state_r <= S_C_NUM; end
        S_C_NUM:  if (cap) begin y_r <= cap_val; state_r <= S_C_DIV; end
        S_C_DIV:  if (cap) begin conf_r <= cap_val[CONF_BITS-1:0]; state_r <= S_FLOOR; end
        S_E_EST:  if (cap) begin est_r <= cap_val[EST_BITS-1:0]; state_r <= S_E_TT; end
        S_E_TT:   if (cap) begin x_r <= cap_val; state_r <= S_E_TTT; end
        S_E_TTT:  if (cap) begin x_r <= cap_val; state_r <= S_E_TD2; end
        S_E_TD2:  if (cap) begin x_r <= cap_val; state_r <= S_E_HG; end
        S_E_HG:   if (cap) begin z_r <= cap_val; state_r <= S_E_DIV; end
        S_E_DIV:  if (cap) begin conf_r <= cap_val[CONF_BITS-1:0]; state_r <= S_FLOOR; end
        S_N_HI:   if (cap) begin x_r <= cap_val; state_r <= S_N_LO; end
        S_N_LO:   if (cap) begin y_r <= cap_val; state_r <= S_N_ACC; end
        S_N_ACC: begin
          ws_r    <= ws_sum[ACC_BITS] ? ACC_MAX : ws_sum[ACC_BITS-1:0];
          cs_r    <= cs_sum[CONF_BITS] ? CONF_MAX : cs_sum[CONF_BITS-1:0];
          seen_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        S_K_SX:   if (cap) begin sx_r <= cap_val[EST_BITS-1:0]; state_r <= S_K_LE; end
        S_K_LE:   if (cap) begin x_r <= cap_val; state_r <= S_K_SX2; end
        S_K_SX2:  if (cap) begin y_r <= cap_val; state_r <= S_K_EST; end
        S_K_EST: begin
          if (cap) begin
            est_r   <= cap_val[EST_BITS-1:0];
            conf_r  <= dsum[CONF_BITS] ? CONF_MAX : dsum[CONF_BITS-1:0];
            flag_r  <= flag_r | cap_flag | dsum[CONF_BITS];
            state_r <= S_OUT;
          end
        end
        S_FLOOR: begin
          conf_r  <= conf_fl;
          lc_r    <= conf_fl;
          le_r    <= est_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= (cmd_r == CMD_CLOSE);
            out_est_r   <= est_r;
            out_conf_r  <= conf_r;
            out_sx_r    <= sx_r;
            out_sc_r    <= sc_r;
            out_sat_r   <= flag_r;
            state_r     <= S_IDLE;
            if (cmd_r == CMD_CLOSE) begin
              ws_r   <= '0;
              cs_r   <= CONF_BITS'(floor_r);
              seen_r <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_bus.ready              = (state_r == S_IDLE);
  assign cfg_bus.ready             = 1'b1;
  assign out_bus.valid             = out_valid_r;
  assign out_bus.kind              = out_kind_r;
  assign out_bus.estimate          = out_est_r;
  assign out_bus.confidence        = out_conf_r;
  assign out_bus.social_estimate   = out_sx_r;
  assign out_bus.social_confidence = out_sc_r;
  assign out_bus.saturated         = out_sat_r;

endmodule
